// File: rtl/calendar_clock_counter_unit_assert.svh
// Assertion macros shared by the calendar clock RTL.
// Each macro takes a label, the clock, the reset and two expressions.
`ifndef CALENDAR_CLOCK_COUNTER_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_COUNTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define CCC_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("calendar clock assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("calendar clock assertion failed");

`else

`define CCC_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons)
`define CCC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

// File: rtl/ccc_pkg.sv
`timescale 1ns / 1ps

package ccc_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_SET_DATE = 2'd1;
  localparam logic [1:0] KIND_SET_TIME = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_YEAR   = 3'd1;
  localparam logic [2:0] ST_BAD_MONTH  = 3'd2;
  localparam logic [2:0] ST_BAD_DAY    = 3'd3;
  localparam logic [2:0] ST_BAD_HOUR   = 3'd4;
  localparam logic [2:0] ST_BAD_MINUTE = 3'd5;
  localparam logic [2:0] ST_BAD_SECOND = 3'd6;

  // Calendar limits.
  localparam logic [3:0] DECEMBER   = 4'd12;
  localparam logic [3:0] JANUARY    = 4'd1;
  localparam logic [6:0] SEC_PER_MIN = 7'd60;
  localparam logic [4:0] LAST_HOUR  = 5'd23;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [5:0] LAST_SECOND = 6'd59;

  // One result word before packing.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  status;
  } result_t;

  // Days in a month, or zero for a month number outside 1..12.
  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/calendar_clock_counter_unit.sv
`timescale 1ns / 1ps

// Calendar clock: keeps second, minute, hour, day, month and year, starting at
// 00:00:00 on January 1 of BASE_YEAR_VALUE after reset. Each input word is a
// tick (adds tick_seconds to the clock), a set-date or a set-time, and returns
// exactly one output word with a status and the date and time after that word.
// The block takes one word per clock cycle while its skid register is empty;
// the whole update is a single compare-and-carry step ahead of the result
// register. A result register plus one skid register let the input accept
// one more word while the output is stalled. Set-date accepts years
// BASE_YEAR_VALUE..LAST_YEAR_VALUE; a tick that would carry past
// LAST_YEAR_VALUE leaves the clock unchanged. Write tick_seconds only while
// no word is in flight.

`include "calendar_clock_counter_unit_assert.svh"

module calendar_clock_counter_unit #(
  parameter int BASE_YEAR_VALUE = 1980,
  parameter int LAST_YEAR_VALUE = 2107
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: tick_seconds.
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // kind
  input  logic [39:0] s_tdata,   // year[11:0], month[15:12], day[20:16], hour[25:21],
                                 // minute[31:26], second[37:32], zero pad
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[2:0], cur_year[14:3], cur_month[18:15],
                                 // cur_day[23:19], cur_hour[28:24], cur_minute[34:29],
                                 // cur_second[40:35], zero pad
);

  localparam logic [12:0] FIRST_YEAR = 13'(BASE_YEAR_VALUE);
  localparam logic [12:0] LAST_YEAR  = 13'(LAST_YEAR_VALUE);

  // Configuration register.
  logic [5:0] tick_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_seconds <= 6'd1;
    end else if (cfg_wr_en) begin
      tick_seconds <= cfg_wr_data;
    end
  end

  // Clock state.
  logic [5:0] sec_count,   sec_count_next;
  logic [5:0] min_count,   min_count_next;
  logic [4:0] hour_count,  hour_count_next;
  logic [4:0] day_count,   day_count_next;
  logic [3:0] month_count, month_count_next;
  logic [6:0] year_offset, year_offset_next;
  logic [2:0] item_status;

  // Input word fields.
  logic [1:0]  kind;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  assign kind   = s_tuser;
  assign year   = s_tdata[11:0];
  assign month  = s_tdata[15:12];
  assign day    = s_tdata[20:16];
  assign hour   = s_tdata[25:21];
  assign minute = s_tdata[31:26];
  assign second = s_tdata[37:32];

  // Handshake.
  logic in_fire;
  logic out_fire;
  logic skid_valid;

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // Tick carry chain.
  logic [12:0] year_full;
  logic [12:0] year_full_inc;
  logic [6:0]  sec_sum;
  logic [1:0]  sec_carry;
  logic [6:0]  sec_wrapped;
  logic [6:0]  min_sum;
  logic [6:0]  min_wrapped;
  logic [5:0]  hour_sum;
  logic [5:0]  day_sum;
  logic [4:0]  cur_month_len;

  assign year_full     = 13'(year_offset) + FIRST_YEAR;
  assign year_full_inc = year_full + 13'd1;
  assign sec_sum       = 7'(sec_count) + 7'(tick_seconds);
  assign sec_carry     = (sec_sum >= 7'(2 * ccc_pkg::SEC_PER_MIN)) ? 2'd2 :
                         (sec_sum >= ccc_pkg::SEC_PER_MIN)          ? 2'd1 : 2'd0;
  assign sec_wrapped   = sec_sum - 7'(sec_carry * ccc_pkg::SEC_PER_MIN);
  assign min_sum       = 7'(min_count) + 7'(sec_carry);
  assign min_wrapped   = min_sum - ccc_pkg::SEC_PER_MIN;
  assign hour_sum      = 6'(hour_count) + 6'd1;
  assign day_sum       = 6'(day_count) + 6'd1;
  assign cur_month_len = ccc_pkg::month_length(month_count, year_full[1:0] == 2'd0);

  // Set-date checks.
  logic [12:0] set_year;
  logic [4:0]  set_month_len;

  assign set_year      = 13'(year);
  assign set_month_len = ccc_pkg::month_length(month, year[1:0] == 2'd0);

  // Next state and status for the word at the input.
  always_comb begin
    sec_count_next   = sec_count;
    min_count_next   = min_count;
    hour_count_next  = hour_count;
    day_count_next   = day_count;
    month_count_next = month_count;
    year_offset_next = year_offset;
    item_status      = ccc_pkg::ST_OK;
    unique case (kind)
      ccc_pkg::KIND_TICK: begin
        if (sec_carry == 2'd0) begin
          sec_count_next = sec_sum[5:0];
        end else if (min_sum <= 7'(ccc_pkg::LAST_MINUTE)) begin
          sec_count_next = sec_wrapped[5:0];
          min_count_next = min_sum[5:0];
        end else if (hour_sum <= 6'(ccc_pkg::LAST_HOUR)) begin
          sec_count_next  = sec_wrapped[5:0];
          min_count_next  = min_wrapped[5:0];
          hour_count_next = hour_sum[4:0];
        end else if (cur_month_len != 5'd0) begin
          // Day carry; a bad stored month or a year past the end changes nothing.
          if (day_sum <= 6'(cur_month_len)) begin
            sec_count_next  = sec_wrapped[5:0];
            min_count_next  = min_wrapped[5:0];
            hour_count_next = 5'd0;
            day_count_next  = day_sum[4:0];
          end else if (month_count != ccc_pkg::DECEMBER) begin
            sec_count_next   = sec_wrapped[5:0];
            min_count_next   = min_wrapped[5:0];
            hour_count_next  = 5'd0;
            day_count_next   = 5'd1;
            month_count_next = month_count + 4'd1;
          end else if (year_full_inc <= LAST_YEAR) begin
            sec_count_next   = sec_wrapped[5:0];
            min_count_next   = min_wrapped[5:0];
            hour_count_next  = 5'd0;
            day_count_next   = 5'd1;
            month_count_next = ccc_pkg::JANUARY;
            year_offset_next = year_offset + 7'd1;
          end
        end
      end
      ccc_pkg::KIND_SET_DATE: begin
        if (set_year < FIRST_YEAR || set_year > LAST_YEAR) begin
          item_status = ccc_pkg::ST_BAD_YEAR;
        end else if (day == 5'd0) begin
          item_status = ccc_pkg::ST_BAD_DAY;
        end else if (set_month_len == 5'd0) begin
          item_status = ccc_pkg::ST_BAD_MONTH;
        end else if (day > set_month_len) begin
          item_status = ccc_pkg::ST_BAD_DAY;
        end else begin
          year_offset_next = 7'(set_year - FIRST_YEAR);
          month_count_next = month;
          day_count_next   = day;
        end
      end
      ccc_pkg::KIND_SET_TIME: begin
        if (hour > ccc_pkg::LAST_HOUR) begin
          item_status = ccc_pkg::ST_BAD_HOUR;
        end else if (minute > ccc_pkg::LAST_MINUTE) begin
          item_status = ccc_pkg::ST_BAD_MINUTE;
        end else if (second > ccc_pkg::LAST_SECOND) begin
          item_status = ccc_pkg::ST_BAD_SECOND;
        end else begin
          hour_count_next = hour;
          min_count_next  = minute;
          sec_count_next  = second;
        end
      end
      default: begin
        item_status = ccc_pkg::ST_OK;
      end
    endcase
  end

  // State registers advance on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count   <= 6'd0;
      min_count   <= 6'd0;
      hour_count  <= 5'd0;
      day_count   <= 5'd1;
      month_count <= 4'd1;
      year_offset <= 7'd0;
    end else if (in_fire) begin
      sec_count   <= sec_count_next;
      min_count   <= min_count_next;
      hour_count  <= hour_count_next;
      day_count   <= day_count_next;
      month_count <= month_count_next;
      year_offset <= year_offset_next;
    end
  end

  // Result of the word at the input, taken from the updated state.
  ccc_pkg::result_t result;
  logic [12:0]      year_full_next;

  assign year_full_next = 13'(year_offset_next) + FIRST_YEAR;

  always_comb begin
    result.status = item_status;
    result.year   = year_full_next[11:0];
    result.month  = month_count_next;
    result.day    = day_count_next;
    result.hour   = hour_count_next;
    result.minute = min_count_next;
    result.second = sec_count_next;
  end

  // Result register with one skid entry behind it.
  ccc_pkg::result_t out_word;
  ccc_pkg::result_t skid_word;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_fire) begin
        out_word <= result;
      end
    end else if (in_fire) begin
      skid_word <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_word};

  // The skid entry is only ever filled behind a stalled result.
  `CCC_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // Carries keep the time of day in range.
  `CCC_ASSERT_SAME(a_time_in_range, clk, rst, 1'b1,
                   sec_count <= ccc_pkg::LAST_SECOND && min_count <= ccc_pkg::LAST_MINUTE
                   && hour_count <= ccc_pkg::LAST_HOUR)
  // The day of month never falls to zero.
  `CCC_ASSERT_SAME(a_day_nonzero, clk, rst, 1'b1, day_count != 5'd0)
  // A rejected set leaves the whole clock untouched.
  `CCC_ASSERT_NEXT(a_reject_holds, clk, rst, in_fire && item_status != ccc_pkg::ST_OK,
                   $stable(sec_count) && $stable(min_count) && $stable(hour_count)
                   && $stable(day_count) && $stable(month_count) && $stable(year_offset))

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int FIRST_YEAR = 1980;
  localparam int LAST_YEAR = 2107;
  localparam int STALL_LIMIT = 4000;
  localparam int BATCH_WORDS = 113;

  // The kind code that the block leaves unused.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One input word; the low 38 bits line up with s_tdata.
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } clock_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  clock_req_t       pending_words[$];
  ccc_pkg::result_t expected_results[$];
  clock_req_t       next_word;
  ccc_pkg::result_t got_result;
  ccc_pkg::result_t want_result;

  int send_idle_pct = 36;
  int recv_idle_pct = 78;
  int mismatch_count = 0;
  int stall_cycles = 0;
  int n_ticks = 0;
  int n_date_sets = 0;
  int n_time_sets = 0;
  int n_rejected = 0;
  int n_results = 0;
  int n_sent = 0;

  // Predicted clock state and the tick step.
  int tick_step = 1;
  int cal_sec = 0;
  int cal_min = 0;
  int cal_hour = 0;
  int cal_day = 1;
  int cal_month = 1;
  int cal_year_ofs = 0;

  calendar_clock_counter_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always #2 clk = ~clk;

  // Days in a month of the given full year; zero for a month outside 1..12.
  function automatic int days_in_month(input int mon, input int full_year);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return (full_year % 4 == 0) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  // Applies one word to the predicted clock and returns the expected result word.
  function automatic ccc_pkg::result_t apply_word(input clock_req_t w);
    ccc_pkg::result_t r;
    int s, mi, h, d, mo, y, len;
    bit commit;
    r.status = ccc_pkg::ST_OK;
    case (w.kind)
      ccc_pkg::KIND_TICK: begin
        s = cal_sec + tick_step;
        mi = cal_min;
        h = cal_hour;
        d = cal_day;
        mo = cal_month;
        y = cal_year_ofs + FIRST_YEAR;
        commit = 1'b1;
        if (s > ccc_pkg::LAST_SECOND) begin
          mi += s / ccc_pkg::SEC_PER_MIN;
          s %= ccc_pkg::SEC_PER_MIN;
          if (mi > ccc_pkg::LAST_MINUTE) begin
            h += mi / ccc_pkg::SEC_PER_MIN;
            mi %= ccc_pkg::SEC_PER_MIN;
            if (h > ccc_pkg::LAST_HOUR) begin
              len = days_in_month(mo, y);
              h = 0;
              d++;
              if (len == 0) begin
                commit = 1'b0;
              end else if (d > len) begin
                d = 1;
                if (mo == ccc_pkg::DECEMBER) begin
                  mo = ccc_pkg::JANUARY;
                  y++;
                  // Carrying past the last year freezes the clock.
                  if (y > LAST_YEAR) commit = 1'b0;
                end else begin
                  mo++;
                end
              end
            end
          end
        end
        if (commit) begin
          cal_sec = s & 63;
          cal_min = mi & 63;
          cal_hour = h & 31;
          cal_day = d & 31;
          cal_month = mo & 15;
          cal_year_ofs = (y - FIRST_YEAR) & 127;
        end
      end
      ccc_pkg::KIND_SET_DATE: begin
        len = days_in_month(int'(w.month), int'(w.year));
        // Day zero is reported before a bad month.
        if (w.year < FIRST_YEAR || w.year > LAST_YEAR) r.status = ccc_pkg::ST_BAD_YEAR;
        else if (w.day == 0) r.status = ccc_pkg::ST_BAD_DAY;
        else if (len == 0) r.status = ccc_pkg::ST_BAD_MONTH;
        else if (w.day > len) r.status = ccc_pkg::ST_BAD_DAY;
        else begin
          cal_year_ofs = (int'(w.year) - FIRST_YEAR) & 127;
          cal_month = w.month;
          cal_day = w.day;
        end
      end
      ccc_pkg::KIND_SET_TIME: begin
        if (w.hour > ccc_pkg::LAST_HOUR) r.status = ccc_pkg::ST_BAD_HOUR;
        else if (w.minute > ccc_pkg::LAST_MINUTE) r.status = ccc_pkg::ST_BAD_MINUTE;
        else if (w.second > ccc_pkg::LAST_SECOND) r.status = ccc_pkg::ST_BAD_SECOND;
        else begin
          cal_hour = w.hour;
          cal_min = w.minute;
          cal_sec = w.second;
        end
      end
      default: ;
    endcase
    r.year = 12'((cal_year_ofs + FIRST_YEAR) & 4095);
    r.month = 4'(cal_month);
    r.day = 5'(cal_day);
    r.hour = 5'(cal_hour);
    r.minute = 6'(cal_min);
    r.second = 6'(cal_sec);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void push_word(input logic [1:0] kind, input int y, input int mo,
                                    input int d, input int h, input int mi, input int s);
    clock_req_t w;
    w.kind = kind;
    w.year = 12'(y);
    w.month = 4'(mo);
    w.day = 5'(d);
    w.hour = 5'(h);
    w.minute = 6'(mi);
    w.second = 6'(s);
    pending_words.push_back(w);
  endfunction

  // Ticks, unused kinds and mostly valid sets aimed at carry boundaries, with raw noise in every field.
  function automatic clock_req_t random_word();
    clock_req_t w;
    int pick, len;
    w.year = 12'($urandom_range(0, 4095));
    w.month = 4'($urandom_range(0, 15));
    w.day = 5'($urandom_range(0, 31));
    w.hour = 5'($urandom_range(0, 31));
    w.minute = 6'($urandom_range(0, 63));
    w.second = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.kind = ccc_pkg::KIND_TICK;
    end else if (pick < 72) begin
      w.kind = ccc_pkg::KIND_SET_TIME;
      if ($urandom_range(0, 99) < 45) begin
        w.hour = ccc_pkg::LAST_HOUR;
        w.minute = ccc_pkg::LAST_MINUTE;
        w.second = 6'($urandom_range(0, 59));
      end else if ($urandom_range(0, 99) < 60) begin
        w.hour = 5'($urandom_range(0, 23));
        w.minute = 6'($urandom_range(0, 59));
        w.second = 6'($urandom_range(0, 59));
      end
    end else if (pick < 95) begin
      w.kind = ccc_pkg::KIND_SET_DATE;
      if ($urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 3))
          0: w.year = 12'(LAST_YEAR);
          1: w.year = 12'(FIRST_YEAR + 4 * $urandom_range(0, 31));
          default: w.year = 12'($urandom_range(FIRST_YEAR, LAST_YEAR));
        endcase
        w.month = 4'($urandom_range(1, 12));
        len = days_in_month(int'(w.month), int'(w.year));
        w.day = 5'($urandom_range(0, 1) ? len : $urandom_range(1, len));
      end
    end else begin
      w.kind = KIND_UNUSED;
    end
    return w;
  endfunction

  // Sender: present the next pending word once the previous one has gone.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        n_sent++;
        s_tvalid <= 1'b1;
        s_tuser <= next_word.kind;
        s_tdata <= {2'b00, next_word[37:0]};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predict the result word of every accepted input word.
  always @(posedge clk) begin
    if (rst) begin
      tick_step = 1;
      cal_sec = 0;
      cal_min = 0;
      cal_hour = 0;
      cal_day = 1;
      cal_month = 1;
      cal_year_ofs = 0;
    end else begin
      if (cfg_wr_en) tick_step = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        want_result = apply_word({s_tuser, s_tdata[37:0]});
        expected_results.push_back(want_result);
        case (s_tuser)
          ccc_pkg::KIND_TICK: n_ticks++;
          ccc_pkg::KIND_SET_DATE: n_date_sets++;
          ccc_pkg::KIND_SET_TIME: n_time_sets++;
          default: ;
        endcase
        if (want_result.status != ccc_pkg::ST_OK) n_rejected++;
      end
    end
  end

  // Compare every delivered result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result = m_tdata[40:0];
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result word with no prediction pending: %h", m_tdata);
        mismatch_count++;
      end else begin
        want_result = expected_results.pop_front();
        check_field("status", want_result.status, got_result.status);
        check_field("cur_year", want_result.year, got_result.year);
        check_field("cur_month", want_result.month, got_result.month);
        check_field("cur_day", want_result.day, got_result.day);
        check_field("cur_hour", want_result.hour, got_result.hour);
        check_field("cur_minute", want_result.minute, got_result.minute);
        check_field("cur_second", want_result.second, got_result.second);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[calendar_clock_counter_unit] ERROR");
        $finish;
      end
    end
  end

  // Waits until every word handed to the sender has come back as a result.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_words.size() != 0 || s_tvalid || n_results != n_sent)
      @(posedge clk);
  endtask

  task automatic write_tick_step(input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 6'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_batch(input int step, input int n_words);
    write_tick_step(step);
    repeat (n_words) pending_words.push_back(random_word());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset tick step of one second.
    push_word(ccc_pkg::KIND_TICK, 4095, 15, 31, 31, 63, 63);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 23, 59, 59);
    push_word(ccc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, FIRST_YEAR - 1, 1, 1, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, LAST_YEAR + 1, 1, 1, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, LAST_YEAR, 13, 0, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, 2024, 0, 5, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, 2023, 2, 29, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, 2024, 2, 29, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 23, 59, 59);
    push_word(ccc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 24, 0, 0);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 31, 63, 63);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 23, 60, 0);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 0, 0, 63);
    // New Year's Eve of the last year: the carry must not wrap the clock.
    push_word(ccc_pkg::KIND_SET_DATE, LAST_YEAR, 12, 31, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 23, 59, 59);
    push_word(ccc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_DATE, FIRST_YEAR, 4, 30, 0, 0, 0);
    push_word(ccc_pkg::KIND_SET_TIME, 0, 0, 0, 23, 59, 59);
    push_word(ccc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
    push_word(KIND_UNUSED, 4095, 15, 31, 31, 63, 63);
    push_word(ccc_pkg::KIND_SET_DATE, 2100, 2, 29, 0, 0, 0);
    wait_drained();

    // A zero tick step leaves the clock alone.
    write_tick_step(0);
    push_word(ccc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
    push_word(ccc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
    wait_drained();

    run_batch(59, BATCH_WORDS);
    run_batch(1, BATCH_WORDS);
    send_idle_pct = 78;
    recv_idle_pct = 36;
    run_batch(46, BATCH_WORDS);
    run_batch($urandom_range(1, 59), BATCH_WORDS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_batch(1, BATCH_WORDS);
    run_batch(59, BATCH_WORDS);

    repeat (8) @(posedge clk);
    $display("Checked %0d result words: %0d ticks, %0d date sets, %0d time sets, %0d rejected,",
             n_results, n_ticks, n_date_sets, n_time_sets, n_rejected);
    $display("over tick steps of 0, 1, 46, 59 and a random one, under three stall patterns.");
    if (mismatch_count == 0) begin
      $display("[calendar_clock_counter_unit] OK");
    end else begin
      $display("[calendar_clock_counter_unit] ERROR");
    end
    $finish;
  end

endmodule
